@@ src/assert_macros.svh @@
// assertion macros used by uart_rx_ring_buffer_find
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define URRBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define URRBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/urrbf_pkg.sv @@
// types and constants for the uart receiver with ring buffer search
// used by urrbf_rx and uart_rx_ring_buffer_find
package urrbf_pkg;

  localparam int unsigned CW = 5;   // request count, offset and fill width
  localparam int unsigned BW = 8;   // byte width
  localparam int unsigned TW = 16;  // tick counter and timing register width

  localparam logic [CW-1:0] SEARCH_MAX = 5'd31;

  localparam logic [TW-1:0] START_DELAY_RST = 16'd576;
  localparam logic [TW-1:0] BIT_PERIOD_RST  = 16'd1152;

  // configuration register indexes
  localparam logic [0:0] REG_START_DELAY = 1'b0;
  localparam logic [0:0] REG_BIT_PERIOD  = 1'b1;

  typedef enum logic [2:0] {
    FUNC_NONE  = 3'd0,
    FUNC_POP   = 3'd1,
    FUNC_FIND  = 3'd2,
    FUNC_UNTIL = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic          valid;
    logic [BW-1:0] data;
  } rx_push_t;

endpackage

@@ src/urrbf_rx.sv @@
// 8n1 receive sampler, advanced once per accepted tick beat
// depends on urrbf_pkg; hands each finished byte to the ring as a push
module urrbf_rx (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    level_i,
  input  logic [urrbf_pkg::TW-1:0] start_delay_i,
  input  logic [urrbf_pkg::TW-1:0] bit_period_i,
  output urrbf_pkg::rx_push_t     push_o
);
  import urrbf_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_HIGH,
    PH_ARMED,
    PH_START,
    PH_DATA
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [TW-1:0] cnt_q, cnt_d;
  logic [3:0]    bits_q, bits_d;
  logic [BW-1:0] shift_q, shift_d;

  logic [TW-1:0] limit, limit_eff, cnt_inc;
  logic          done;

  assign limit     = (phase_q == PH_START) ? start_delay_i : bit_period_i;
  assign limit_eff = (limit == '0) ? TW'(1) : limit;
  assign cnt_inc   = cnt_q + TW'(1);
  assign done      = (cnt_inc >= limit_eff);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    push_o  = '0;
    if (tick_i) begin
      unique case (phase_q)
        PH_WAIT_HIGH: begin
          if (level_i) phase_d = PH_ARMED;
        end
        PH_ARMED: begin
          if (!level_i) begin
            phase_d = PH_START;
            cnt_d   = '0;
            bits_d  = '0;
            shift_d = '0;
          end
        end
        PH_START: begin
          cnt_d = done ? '0 : cnt_inc;
          if (done) phase_d = PH_DATA;
        end
        PH_DATA: begin
          cnt_d = done ? '0 : cnt_inc;
          if (done) begin
            // lsb first: new bit enters at the top
            shift_d = {level_i, shift_q[BW-1:1]};
            bits_d  = bits_q + 4'd1;
            if (bits_d >= 4'd8) begin
              push_o.valid = 1'b1;
              push_o.data  = shift_d;
              bits_d       = '0;
              phase_d      = PH_WAIT_HIGH;
            end
          end
        end
        default: phase_d = PH_WAIT_HIGH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_HIGH;
      cnt_q   <= '0;
      bits_q  <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
    end
  end

endmodule

@@ src/uart_rx_ring_buffer_find.sv @@
// uart 8n1 receiver feeding an overwriting ring, with pop, find, read-until and clear
// depends on urrbf_pkg, urrbf_rx and assert_macros.svh
//
// each input beat is one timer tick: tdata carries the sampled line level, the
// pop count and the match character, tuser the request code. the receiver step
// for the tick is taken in the cycle the beat is accepted; a byte completed on
// that tick is stored before the request is served.
// results leave on the master side, one beat per popped byte (tlast on the
// final one), or a single beat with tlast for find, clear, zero-count pop, short and not-found.
// timing: tready is high only while the sequencer is idle. a tick with no
// request is accepted and then decoded; short, empty and clear requests then
// send their result beat; pop reads each byte as a registered read of the
// single read port; find walks the ring through that same port, one entry
// per cycle, over at most 31 bytes, and read-until then pops the bytes up to
// the match. results go through one output register, so the next beat is
// accepted while a result still waits; a stalled receiver holds the sequencer
// before its next output load.
// reset: ring empty, receiver waiting for a high line, timing registers back
// to 576 and 1152 ticks; ring contents need no clearing.
module uart_rx_ring_buffer_find #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // tick and request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_level, request_count[4:0], match_char[7:0]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_byte[7:0], match_offset[4:0], fill_level[4:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast
);
  import urrbf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = (PW > CW) ? PW : CW;
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_POP_RD,
    S_POP_WR,
    S_SEND
  } state_e;

  state_e        state_q;
  func_e         func_q;
  logic [CW-1:0] cnt_q, scan_idx_q, cmp_idx_q, lim_q, fill_after_q;
  logic          cmp_vld_q;
  logic [BW-1:0] ch_q;
  logic [CW-1:0] res_off_q, res_fill_q;
  status_e       res_st_q;

  logic [TW-1:0] start_delay_q, bit_period_q;
  logic [PW-1:0] wp_q, rp_q;

  logic          out_vld_q, out_last_q;
  logic [BW-1:0] out_data_q;
  logic [CW-1:0] out_off_q, out_fill_q;
  status_e       out_st_q;

  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] rdata_q;

  rx_push_t      push;
  logic          acc, out_free, out_load;
  logic          pop_busy, pop_final;
  logic [PW-1:0] wp_nx, rp_nx, rp_after_push, raddr;
  logic [PW:0]   fill_raw;
  logic [PW-1:0] fill;
  logic [EW-1:0] fill_e;
  logic [CW-1:0] off;
  logic [EW:0]   addr_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign out_load      = (state_q == S_POP_WR) || ((state_q == S_SEND) && out_free);
  assign pop_busy      = (state_q == S_POP_RD) || (state_q == S_POP_WR);
  assign pop_final     = (state_q == S_POP_WR) && (cnt_q == CW'(1));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= START_DELAY_RST;
      bit_period_q  <= BIT_PERIOD_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_START_DELAY) start_delay_q <= cfg_data_i;
      if (cfg_idx_i == REG_BIT_PERIOD)  bit_period_q  <= cfg_data_i;
    end
  end

  urrbf_rx u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (acc),
    .level_i       (s_axis_tdata[0]),
    .start_delay_i (start_delay_q),
    .bit_period_i  (bit_period_q),
    .push_o        (push)
  );

  // ring pointer arithmetic
  assign wp_nx = (wp_q == PTR_MAX) ? '0 : wp_q + PW'(1);
  assign rp_nx = (rp_q == PTR_MAX) ? '0 : rp_q + PW'(1);
  assign rp_after_push = (wp_nx == rp_q) ? rp_nx : rp_q;

  assign fill_raw = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
                                   : ({1'b0, wp_q} + (PW+1)'(DEPTH) - {1'b0, rp_q});
  assign fill     = fill_raw[PW-1:0];
  assign fill_e   = EW'(fill);

  // shared address unit: oldest entry plus offset, wrapped once
  assign off      = (state_q == S_SCAN) ? scan_idx_q : '0;
  assign addr_sum = (EW+1)'(rp_q) + (EW+1)'(off);
  assign raddr    = (addr_sum >= (EW+1)'(DEPTH)) ? PW'(addr_sum - (EW+1)'(DEPTH))
                                                 : PW'(addr_sum);

  always_ff @(posedge clk_i) begin
    if (acc && push.valid) mem[wp_q] <= push.data;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= FUNC_NONE;
      cnt_q        <= '0;
      scan_idx_q   <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      lim_q        <= '0;
      fill_after_q <= '0;
      ch_q         <= '0;
      res_off_q    <= '0;
      res_fill_q   <= '0;
      res_st_q     <= ST_OK;
      wp_q         <= '0;
      rp_q         <= '0;
      out_vld_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_data_q   <= '0;
      out_off_q    <= '0;
      out_fill_q   <= '0;
      out_st_q     <= ST_OK;
    end else begin
      if (out_vld_q && m_axis_tready && !out_load) out_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            func_q  <= func_e'(s_axis_tuser);
            cnt_q   <= s_axis_tdata[5:1];
            ch_q    <= s_axis_tdata[13:6];
            state_q <= S_CMD;
            // clear wins over a byte landing on the same tick
            if (func_e'(s_axis_tuser) == FUNC_CLEAR) begin
              wp_q <= '0;
              rp_q <= '0;
            end else if (push.valid) begin
              wp_q <= wp_nx;
              rp_q <= rp_after_push;
            end
          end
        end

        S_CMD: begin
          res_off_q <= '0;
          unique case (func_q)
            FUNC_POP: begin
              res_fill_q <= CW'(fill_e);
              if (EW'(cnt_q) > fill_e) begin
                res_st_q <= ST_SHORT;
                state_q  <= S_SEND;
              end else if (cnt_q == '0) begin
                res_st_q <= ST_OK;
                state_q  <= S_SEND;
              end else begin
                res_st_q     <= ST_OK;
                fill_after_q <= CW'(fill_e - EW'(cnt_q));
                state_q      <= S_POP_RD;
              end
            end
            FUNC_FIND, FUNC_UNTIL: begin
              scan_idx_q <= '0;
              cmp_vld_q  <= 1'b0;
              lim_q      <= (fill_e > EW'(SEARCH_MAX)) ? SEARCH_MAX : CW'(fill_e);
              state_q    <= S_SCAN;
            end
            FUNC_CLEAR: begin
              res_fill_q <= '0;
              res_st_q   <= ST_OK;
              state_q    <= S_SEND;
            end
            default: state_q <= S_IDLE;
          endcase
        end

        S_SCAN: begin
          // compare the entry read last cycle while the next one is fetched
          if (cmp_vld_q && (rdata_q == ch_q)) begin
            if (func_q == FUNC_FIND) begin
              res_off_q  <= cmp_idx_q;
              res_fill_q <= CW'(fill_e);
              res_st_q   <= ST_OK;
              state_q    <= S_SEND;
            end else begin
              cnt_q        <= cmp_idx_q + CW'(1);
              fill_after_q <= CW'(fill_e - EW'(cmp_idx_q) - EW'(1));
              state_q      <= S_POP_RD;
            end
          end else if (scan_idx_q == lim_q) begin
            res_off_q  <= '0;
            res_fill_q <= CW'(fill_e);
            res_st_q   <= ST_NOT_FOUND;
            state_q    <= S_SEND;
          end else begin
            cmp_vld_q  <= 1'b1;
            cmp_idx_q  <= scan_idx_q;
            scan_idx_q <= scan_idx_q + CW'(1);
          end
        end

        S_POP_RD: begin
          if (out_free) state_q <= S_POP_WR;
        end

        S_POP_WR: begin
          out_vld_q  <= 1'b1;
          out_data_q <= rdata_q;
          out_off_q  <= '0;
          out_st_q   <= ST_OK;
          out_fill_q <= fill_after_q;
          out_last_q <= (cnt_q == CW'(1));
          rp_q       <= rp_nx;
          cnt_q      <= cnt_q - CW'(1);
          state_q    <= (cnt_q == CW'(1)) ? S_IDLE : S_POP_RD;
        end

        S_SEND: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= '0;
            out_off_q  <= res_off_q;
            out_st_q   <= res_st_q;
            out_fill_q <= res_fill_q;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_fill_q, out_off_q, out_data_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

`include "assert_macros.svh"

  `URRBF_ASSERT(a_ptr_range, (wp_q <= PTR_MAX) && (rp_q <= PTR_MAX), "ring pointer out of range")
  `URRBF_ASSERT(a_pop_cnt, pop_busy |-> (cnt_q != '0), "pop with zero count")
  `URRBF_ASSERT_NEXT(a_pop_last, pop_final, (state_q == S_IDLE) && m_axis_tlast, "last unmarked")

endmodule

@@ bench/uart_rx_ring_buffer_find_test.sv @@
// self-checking bench for uart_rx_ring_buffer_find: line ticks, host requests, timing registers
// depends on urrbf_pkg and the rtl of uart_rx_ring_buffer_find; predicts every result beat itself
`timescale 1ns / 100ps

module uart_rx_ring_buffer_find_test;
  import urrbf_pkg::*;

  localparam int unsigned RING_DEPTH    = 32;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 300;

  // request codes the block must ignore
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    LINE_WAIT_HIGH,
    LINE_ARMED,
    LINE_START,
    LINE_DATA
  } line_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [4:0] match_offset;
    status_e    status;
    logic       last;
    logic [4:0] fill_level;
  } result_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // rx_level, request_count[4:0], match_char[7:0]
  logic [2:0]  s_axis_tuser  = '0;  // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // data_byte[7:0], match_offset[4:0], fill_level[4:0]
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        m_axis_tlast;

  // predicted state of the receiver and the ring
  logic [7:0]   ring_copy [RING_DEPTH];
  logic [4:0]   wr_idx;
  logic [4:0]   rd_idx;
  line_phase_e  line_phase;
  logic [15:0]  tick_cnt;
  logic [3:0]   bits_got;
  logic [7:0]   shifter;
  logic [15:0]  start_delay_reg;
  logic [15:0]  bit_period_reg;

  result_beat_t result_beats_due [$];
  int unsigned  fail_count    = 0;
  bit           calm_mode     = 1'b0;
  bit           hold_off_req  = 1'b0;

  uart_rx_ring_buffer_find #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin : reset_gen
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : ring_model_reset
    foreach (ring_copy[i]) ring_copy[i] = 8'h00;
    wr_idx          = '0;
    rd_idx          = '0;
    line_phase      = LINE_WAIT_HIGH;
    tick_cnt        = '0;
    bits_got        = '0;
    shifter         = '0;
    start_delay_reg = START_DELAY_RST;
    bit_period_reg  = BIT_PERIOD_RST;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [4:0] stored_count();
    return wr_idx - rd_idx;
  endfunction

  // one tick of a wait phase; a limit of zero behaves as one
  function automatic bit wait_over(input logic [15:0] limit);
    logic [15:0] lim;
    lim      = (limit == '0) ? 16'd1 : limit;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // offset of the first match among the oldest bytes, -1 if none
  function automatic int locate_char(input logic [7:0] c);
    int lim;
    lim = int'(stored_count());
    if (lim > int'(SEARCH_MAX)) lim = int'(SEARCH_MAX);
    for (int i = 0; i < lim; i++)
      if (ring_copy[5'(rd_idx + i)] == c) return i;
    return -1;
  endfunction

  function automatic result_beat_t make_beat(input logic [7:0] d, input logic [4:0] off,
                                             input status_e st, input logic [4:0] fill);
    result_beat_t b;
    b.data_byte    = d;
    b.match_offset = off;
    b.status       = st;
    b.last         = 1'b1;
    b.fill_level   = fill;
    return b;
  endfunction

  task automatic take_bytes(input int cnt);
    result_beat_t popped [$];
    result_beat_t b;
    if (cnt > int'(stored_count())) begin
      result_beats_due.push_back(make_beat(8'h00, 5'd0, ST_SHORT, stored_count()));
    end else if (cnt == 0) begin
      result_beats_due.push_back(make_beat(8'h00, 5'd0, ST_OK, stored_count()));
    end else begin
      for (int i = 0; i < cnt; i++) begin
        b      = make_beat(ring_copy[rd_idx], 5'd0, ST_OK, 5'd0);
        b.last = (i == cnt - 1);
        popped.push_back(b);
        rd_idx = rd_idx + 5'd1;
      end
      // every beat of a pop reports the level after the whole pop
      foreach (popped[i]) begin
        popped[i].fill_level = stored_count();
        result_beats_due.push_back(popped[i]);
      end
    end
  endtask

  // receiver step for one accepted tick, then the host request it carries
  task automatic tick_results(input logic level, input logic [2:0] f,
                              input logic [4:0] n, input logic [7:0] c);
    int pos;
    case (line_phase)
      LINE_WAIT_HIGH: if (level) line_phase = LINE_ARMED;
      LINE_ARMED: begin
        if (!level) begin
          line_phase = LINE_START;
          tick_cnt   = '0;
          bits_got   = '0;
          shifter    = '0;
        end
      end
      LINE_START: if (wait_over(start_delay_reg)) line_phase = LINE_DATA;
      default: begin
        if (wait_over(bit_period_reg)) begin
          shifter  = {level, shifter[7:1]};
          bits_got = bits_got + 4'd1;
          if (bits_got >= 4'd8) begin
            ring_copy[wr_idx] = shifter;
            wr_idx = wr_idx + 5'd1;
            // full ring drops its oldest byte
            if (wr_idx == rd_idx) rd_idx = rd_idx + 5'd1;
            bits_got   = '0;
            line_phase = LINE_WAIT_HIGH;
          end
        end
      end
    endcase

    case (f)
      FUNC_POP: take_bytes(int'(n));
      FUNC_FIND: begin
        pos = locate_char(c);
        if (pos < 0)
          result_beats_due.push_back(make_beat(8'h00, 5'd0, ST_NOT_FOUND, stored_count()));
        else
          result_beats_due.push_back(make_beat(8'h00, 5'(pos), ST_OK, stored_count()));
      end
      FUNC_UNTIL: begin
        pos = locate_char(c);
        if (pos < 0)
          result_beats_due.push_back(make_beat(8'h00, 5'd0, ST_NOT_FOUND, stored_count()));
        else
          take_bytes(pos + 1);
      end
      FUNC_CLEAR: begin
        foreach (ring_copy[i]) ring_copy[i] = 8'h00;
        wr_idx = '0;
        rd_idx = '0;
        result_beats_due.push_back(make_beat(8'h00, 5'd0, ST_OK, 5'd0));
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        pause        = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        pause = calm_mode ? 0 : $urandom_range(0, 11);
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_beat_t got;
    result_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data_byte    = m_axis_tdata[7:0];
      got.match_offset = m_axis_tdata[12:8];
      got.fill_level   = m_axis_tdata[17:13];
      got.status       = status_e'(m_axis_tuser);
      got.last         = m_axis_tlast;
      if (result_beats_due.size() == 0) begin
        $error("result beat with nothing outstanding: data_byte %0h", got.data_byte);
        fail_count++;
      end else begin
        want = result_beats_due.pop_front();
        if (got.data_byte !== want.data_byte) begin
          $error("data_byte expected %0h got %0h", want.data_byte, got.data_byte);
          fail_count++;
        end
        if (got.match_offset !== want.match_offset) begin
          $error("match_offset expected %0d got %0d", want.match_offset, got.match_offset);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0b got %0b", want.last, got.last);
          fail_count++;
        end
        if (got.fill_level !== want.fill_level) begin
          $error("fill_level expected %0d got %0d", want.fill_level, got.fill_level);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tick side

  task automatic drive_tick(input logic level, input logic [2:0] f,
                            input logic [4:0] n, input logic [7:0] c);
    int unsigned gap;
    gap = calm_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c, n, level};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    tick_results(level, f, n, c);
  endtask

  // block idle: no beat offered, nothing outstanding, trailing cycles spent
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (result_beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START_DELAY) start_delay_reg = value;
    else bit_period_reg = value;
  endtask

  // random request; the character is often one that sits in the ring
  task automatic pick_request(input int unsigned pct, input bit pops_ok,
                              output logic [2:0] f, output logic [4:0] n,
                              output logic [7:0] c);
    int unsigned roll;
    logic [4:0]  fill;
    fill = stored_count();
    f    = FUNC_NONE;
    n    = 5'($urandom);
    c    = 8'($urandom);
    if (fill != 0 && $urandom_range(0, 1) == 1)
      c = ring_copy[5'(rd_idx + $urandom_range(0, fill - 1))];
    if (fill < 5'd31 && $urandom_range(0, 2) != 0)
      n = 5'($urandom_range(0, fill + 1));
    if ($urandom_range(0, 99) < pct) begin
      roll = $urandom_range(0, 19);
      if (!pops_ok && roll >= 8 && roll < 17) roll = 0;
      if (roll < 8)       f = FUNC_FIND;
      else if (roll < 11) f = FUNC_UNTIL;
      else if (roll < 16) f = FUNC_POP;
      else if (roll < 17) f = FUNC_CLEAR;
      else                f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    end
  endtask

  // line level on tick k of a frame: arm high, start low, start wait, 8 data bits
  function automatic logic frame_level(input logic [7:0] b, input int k,
                                       input int sd, input int bp);
    if (k == 0) return 1'b1;
    if (k < 2 + sd) return 1'b0;
    return b[(k - 2 - sd) / bp];
  endfunction

  task automatic send_frame(input logic [7:0] b, input int unsigned pct, input bit pops_ok);
    int         sd;
    int         bp;
    logic [2:0] f;
    logic [4:0] n;
    logic [7:0] c;
    sd = (start_delay_reg == '0) ? 1 : int'(start_delay_reg);
    bp = (bit_period_reg == '0) ? 1 : int'(bit_period_reg);
    for (int k = 0; k < 2 + sd + 8 * bp; k++) begin
      pick_request(pct, pops_ok, f, n, c);
      drive_tick(frame_level(b, k, sd, bp), f, n, c);
    end
  endtask

  task automatic send_noise(input int len, input int unsigned pct, input bit pops_ok);
    logic [2:0] f;
    logic [4:0] n;
    logic [7:0] c;
    for (int k = 0; k < len; k++) begin
      pick_request(pct, pops_ok, f, n, c);
      drive_tick(1'($urandom), f, n, c);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // empty-ring requests, bytes 0x00 and 0xff, ignored codes, field extremes
  task automatic test_directed();
    logic [2:0] f;
    logic [4:0] n;
    logic [7:0] c;
    write_reg(REG_START_DELAY, 16'd1);
    write_reg(REG_BIT_PERIOD, 16'd1);
    for (int k = 0; k < 11; k++) begin
      f = FUNC_NONE;
      n = 5'd0;
      c = 8'h00;
      case (k)
        0: begin
          f = FUNC_POP;
          n = 5'd31;
        end
        1: begin
          f = FUNC_UNTIL;
          c = 8'hff;
        end
        2: f = FUNC_FIND;
        3: f = FUNC_POP;
        4: f = FUNC_UNUSED_LO;
        5: f = FUNC_CLEAR;
        10: f = FUNC_FIND;  // byte lands on this tick, found at the head
        default: ;
      endcase
      drive_tick(frame_level(8'h00, k, 1, 1), f, n, c);
    end
    for (int k = 0; k < 11; k++) begin
      f = FUNC_NONE;
      n = 5'd0;
      c = 8'hff;
      if (k == 4) begin
        f = FUNC_UNUSED_HI;
        n = 5'd31;
      end
      if (k == 10) f = FUNC_FIND;
      drive_tick(frame_level(8'hff, k, 1, 1), f, n, c);
    end
    drive_tick(1'b1, FUNC_FIND, 5'd0, 8'h5a);
    drive_tick(1'b1, FUNC_UNTIL, 5'd0, 8'hff);
    drain_results();
  endtask

  // more bytes than the ring holds, nothing taken out, searches across the wrap
  task automatic test_ring_overwrite();
    calm_mode = 1'b1;
    for (int i = 0; i < 32; i++) begin
      if (i == 8) calm_mode = 1'b0;
      send_frame(8'($urandom), 12, 1'b0);
    end
    drain_results();
  endtask

  // all requests mixed, broken frames, and a long receiver hold on a full ring
  task automatic test_mixed_requests();
    write_reg(REG_START_DELAY, 16'd2);
    write_reg(REG_BIT_PERIOD, 16'd2);
    hold_off_req = 1'b1;
    calm_mode    = 1'b1;
    drive_tick(1'b1, FUNC_POP, 5'd31, 8'h00);
    for (int i = 0; i < 12; i++) drive_tick(1'b1, FUNC_FIND, 5'd0, 8'($urandom));
    calm_mode = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(2, 12), 35, 1'b1);
      else send_frame(8'($urandom), 35, 1'b1);
    end
    drain_results();
  endtask

  // longest waits leave the receiver counting; then a short start wait picks up mid-count
  task automatic test_timing_extremes();
    write_reg(REG_START_DELAY, 16'hffff);
    write_reg(REG_BIT_PERIOD, 16'hffff);
    drive_tick(1'b1, FUNC_FIND, 5'd0, 8'($urandom));
    drive_tick(1'b0, FUNC_POP, 5'd1, 8'h00);
    send_noise(8, 60, 1'b1);
    drain_results();
    write_reg(REG_START_DELAY, 16'd3);
    write_reg(REG_BIT_PERIOD, 16'd1);
    send_noise(6, 40, 1'b1);
    for (int i = 0; i < 2; i++) send_frame(8'($urandom), 30, 1'b1);
    drain_results();
  endtask

  initial begin : main_sequence
    wait (rst_ni);
    @(posedge clk_i);
    test_directed();
    test_ring_overwrite();
    test_mixed_requests();
    test_timing_extremes();
    if (fail_count == 0) begin
      $display("uart_rx_ring_buffer_find_test: clean");
    end else begin
      $display("uart_rx_ring_buffer_find_test: errors");
    end
    $finish;
  end

  initial begin : run_limit
    #10ms;
    $display("uart_rx_ring_buffer_find_test: errors");
    $finish;
  end

endmodule
